@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, checked on every rising edge outside reset.
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked on the edge after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gfas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gfas_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_BUCKETS = 5;
  localparam int BUCKET_W    = 3;
  localparam int MAG_W       = 31;
  localparam int GROUP_W     = 3;
  localparam int OUT_CNT_W   = 32;
  localparam int OUT_DATA_W  = 96;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [MAG_W-1:0]       mag_t;
  typedef logic [BUCKET_W-1:0]    bucket_t;
  typedef logic [GROUP_W-1:0]     group_t;

  localparam mag_t INF_BITS = 31'h7F80_0000;

  localparam group_t GROUP_GLOBAL    = 3'd3;
  localparam group_t GROUP_DEC_SELF  = 3'd4;
  localparam group_t GROUP_DEC_CROSS = 3'd5;
  localparam group_t GROUP_HEAD      = 3'd6;

  localparam bucket_t BUCKET_HEAD_FIRST = 3'd0;
  localparam bucket_t BUCKET_HEAD_LATER = 3'd1;
  localparam bucket_t BUCKET_DECODER    = 3'd2;
  localparam bucket_t BUCKET_GLOBAL     = 3'd3;
  localparam bucket_t BUCKET_ENCODER    = 3'd4;

  function automatic bucket_t pick_bucket(input group_t grp, input logic head_done);
    bucket_t b;
    case (grp)
      GROUP_HEAD:      b = head_done ? BUCKET_HEAD_LATER : BUCKET_HEAD_FIRST;
      GROUP_DEC_SELF:  b = BUCKET_DECODER;
      GROUP_DEC_CROSS: b = BUCKET_DECODER;
      GROUP_GLOBAL:    b = BUCKET_GLOBAL;
      default:         b = BUCKET_ENCODER;
    endcase
    return b;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + count_t'(1);
  endfunction

  // Low 32 bits of a count, zero-extended when the count is narrower.
  function automatic logic [OUT_CNT_W-1:0] count_to_out(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/grouped_float_anomaly_scanner_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata (low bit up)                          tuser (low bit up)         tlast
// s_       in   value[31:0]                                 element_valid,group[2:0],  pass_end
//                                                           tensor_last
// m_       out  max_magnitude[30:0],nan_total[31:0],        bucket[2:0]                last_of_run
//               inf_total[31:0],one zero pad bit
//
// One item is accepted per cycle unless a pass-end item is held in the input register; it is
// registered, then folded into its bucket. A pass-end item copies the five buckets into a
// drain buffer and clears them in the same cycle; the five results leave at one per cycle,
// while m_tready allows, through the output register once the drain buffer is loaded.
// A second pass-end item waits in the input register until the drain buffer is empty.
// rst is synchronous and clears all buckets, head_done and both valid flags.

`include "assert_macros.svh"

module grouped_float_anomaly_scanner_core
  import gfas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,   // value
  input  wire logic [4:0]            s_tuser,   // element_valid, group, tensor_last
  input  wire logic                  s_tlast,   // pass_end
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // max_magnitude, nan_total, inf_total, pad
  output logic [BUCKET_W-1:0]        m_tuser,   // bucket
  output logic                       m_tlast    // last_of_run
);

  // Input register
  logic        in_valid;
  logic [31:0] in_value;
  logic        in_elem;
  group_t      in_group;
  logic        in_tensor_last;
  logic        in_pass_end;

  // Live bucket state
  mag_t   bucket_max  [NUM_BUCKETS];
  count_t bucket_nans [NUM_BUCKETS];
  count_t bucket_infs [NUM_BUCKETS];
  logic   head_done;

  // Drain buffer
  mag_t    drain_max  [NUM_BUCKETS];
  count_t  drain_nans [NUM_BUCKETS];
  count_t  drain_infs [NUM_BUCKETS];
  logic    drain_busy;
  bucket_t drain_idx;

  mag_t   upd_max  [NUM_BUCKETS];
  count_t upd_nans [NUM_BUCKETS];
  count_t upd_infs [NUM_BUCKETS];
  logic   head_done_next;
  logic   advance;
  logic   out_load;
  bucket_t cur_bucket;
  mag_t    cur_mag;

  assign advance  = in_valid && !(in_pass_end && drain_busy);
  assign s_tready = !in_valid || advance;
  assign out_load = drain_busy && (!m_tvalid || m_tready);

  assign cur_bucket = pick_bucket(in_group, head_done);
  assign cur_mag    = in_value[MAG_W-1:0];
  assign head_done_next = head_done || (in_tensor_last && (in_group == GROUP_HEAD));

  always_comb begin
    for (int k = 0; k < NUM_BUCKETS; k++) begin
      upd_max[k]  = bucket_max[k];
      upd_nans[k] = bucket_nans[k];
      upd_infs[k] = bucket_infs[k];
      if (in_elem && (cur_bucket == bucket_t'(k))) begin
        if (cur_mag > INF_BITS) begin
          upd_nans[k] = sat_inc(bucket_nans[k]);
        end else begin
          if (cur_mag == INF_BITS) begin
            upd_infs[k] = sat_inc(bucket_infs[k]);
          end
          if (cur_mag > bucket_max[k]) begin
            upd_max[k] = cur_mag;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_value       <= s_tdata;
      in_elem        <= s_tuser[0];
      in_group       <= s_tuser[3:1];
      in_tensor_last <= s_tuser[4];
      in_pass_end    <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_done <= 1'b0;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        bucket_max[k]  <= '0;
        bucket_nans[k] <= '0;
        bucket_infs[k] <= '0;
      end
    end else if (advance) begin
      if (in_pass_end) begin
        head_done <= 1'b0;
        for (int k = 0; k < NUM_BUCKETS; k++) begin
          bucket_max[k]  <= '0;
          bucket_nans[k] <= '0;
          bucket_infs[k] <= '0;
        end
      end else begin
        head_done <= head_done_next;
        for (int k = 0; k < NUM_BUCKETS; k++) begin
          bucket_max[k]  <= upd_max[k];
          bucket_nans[k] <= upd_nans[k];
          bucket_infs[k] <= upd_infs[k];
        end
      end
    end
  end

  // The pass-end item is folded in before the snapshot is taken.
  always_ff @(posedge clk) begin
    if (advance && in_pass_end) begin
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        drain_max[k]  <= upd_max[k];
        drain_nans[k] <= upd_nans[k];
        drain_infs[k] <= upd_infs[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_busy <= 1'b0;
      drain_idx  <= BUCKET_HEAD_FIRST;
    end else if (advance && in_pass_end) begin
      drain_busy <= 1'b1;
      drain_idx  <= BUCKET_HEAD_FIRST;
    end else if (out_load) begin
      if (drain_idx == BUCKET_ENCODER) begin
        drain_busy <= 1'b0;
        drain_idx  <= BUCKET_HEAD_FIRST;
      end else begin
        drain_idx <= drain_idx + bucket_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {1'b0,
                  count_to_out(drain_infs[drain_idx]),
                  count_to_out(drain_nans[drain_idx]),
                  drain_max[drain_idx]};
      m_tuser <= drain_idx;
      m_tlast <= (drain_idx == BUCKET_ENCODER);
    end
  end

  `ASSERT_SAME_CYCLE(a_drain_idx_range, drain_busy, drain_idx <= BUCKET_ENCODER,
                     "drain index past the last bucket")
  `ASSERT_SAME_CYCLE(a_last_is_encoder, m_tvalid && m_tlast, m_tuser == BUCKET_ENCODER,
                     "last result of a run is not the encoder bucket")
  `ASSERT_SAME_CYCLE(a_max_not_nan, m_tvalid, m_tdata[MAG_W-1:0] <= INF_BITS,
                     "reported maximum is a NaN pattern")
  `ASSERT_NEXT_CYCLE(a_pass_end_starts_drain, advance && in_pass_end,
                     drain_busy && (drain_idx == BUCKET_HEAD_FIRST),
                     "pass end did not start a drain at the first bucket")

endmodule

`default_nettype wire
